[rtl/rars_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rars_pkg: shared types for the range-add / range-sum tree
// Holds the sequencer state encoding used by the top level.
// ----------------------------------------------------------------------------
package rars_pkg;

  localparam int unsigned ACTION_ADD   = 0;
  localparam int unsigned ACTION_QUERY = 1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH_RD,
    ST_PUSH_CHK,
    ST_PUSH_C1,
    ST_PUSH_CLR,
    ST_PUSH_NEXT,
    ST_GIVE_RD,
    ST_GIVE_WR,
    ST_SCAN,
    ST_SCAN_R,
    ST_SCAN_SH,
    ST_QACC,
    ST_REB_A,
    ST_REB_B,
    ST_REB_W,
    ST_OUT
  } state_t;

endpackage

[rtl/range_add_range_sum_tree.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_sum_tree: lazy segment tree, range add and range sum
// Stores LEAVES signed 64-bit cells, adds over ranges and sums ranges.
// ----------------------------------------------------------------------------
// Each transaction on the input stream either adds amount to every cell in
// [first, end_excl) or asks for the wrapped 64-bit sum of that range; only a
// query produces an output transaction. Both bounds are clamped to LEAVES and
// an empty range is a no-op (a query on it returns zero). All work runs one
// item at a time through a single read/write slot per memory and one shared
// add-and-shift unit, so the input is not ready until the item is done. With
// H = log2(LEAVES), an item is first accepted, then on each boundary path it
// pushes pending adds down level by level, reading each pending add and, where
// it is not zero, adding it to both children and clearing it. The range walk
// then climbs the tree (at most H+1 levels), updating each node an add covers
// or summing each node a query covers. An add then rebuilds the ancestors of
// both boundary leaves, and a query hands off its sum, waiting while the
// output is stalled. The pace is set by the one access per cycle into each of
// the node and pending memories. An empty add returns straight to idle and an
// empty query goes straight to the hand-off. After reset the block sweeps both
// memories to zero before it takes its first transaction.
module range_add_range_sum_tree #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // first [9:0], end_excl [20:10], amount [84:21], zero pad
  input  logic        s_tuser,   // action: 0 add, 1 query
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // range_sum [63:0]
);
  import rars_pkg::*;

  localparam int unsigned LOG = $clog2(LEAVES);
  localparam int unsigned AW  = LOG + 1;                 // node address width
  localparam int unsigned SW  = $clog2(LOG + 2);         // level / shift width
  localparam int unsigned CW  = (LOG + 1 > 11) ? LOG + 1 : 11;

  state_t state, state_next;

  // Tree stores: node sums over 2*LEAVES slots, pending adds for internal nodes.
  logic [63:0] node_mem [2*LEAVES];
  logic [63:0] pend_mem [LEAVES];
  logic [63:0] node_rd, pend_rd;
  logic [AW-1:0]  node_ra, node_wa;
  logic [LOG-1:0] pend_ra, pend_wa;
  logic [63:0] node_wd, pend_wd;
  logic        node_we, pend_we;

  // Item registers.
  logic          act;
  logic [63:0]   amt;
  logic [AW-1:0] lo, hi;
  logic          sel;          // 0: lower boundary path, 1: upper boundary path
  logic [SW-1:0] s;            // push level, counts down
  logic [AW-1:0] pi;           // node whose pending add is being pushed
  logic [63:0]   pd;           // pending add captured from pi
  logic [AW:0]   l, r;         // range walk bounds
  logic [SW-1:0] lvl;          // range walk level
  logic [AW-1:0] p;            // rebuild node
  logic [SW-1:0] k;            // rebuild level
  logic [63:0]   a_sum;        // left child sum during rebuild
  logic [63:0]   acc;
  logic [AW-1:0] clr_cnt;

  // Shared add step: node[gaddr] += gamt << gshift, pend[gaddr] += gamt for an internal gaddr.
  logic [AW-1:0] gaddr;
  logic [SW-1:0] gshift;
  logic [63:0]   gamt;
  state_t        gret;

  logic [CW-1:0] first_x, end_x, lim;
  logic [AW-1:0] lo_in, hi_in;
  logic [LOG-1:0] pos;
  logic [AW-1:0]  leaf_pos;
  logic [AW-1:0]  push_i;

  assign lim     = CW'(LEAVES);
  assign first_x = CW'(s_tdata[9:0]);
  assign end_x   = CW'(s_tdata[20:10]);
  assign lo_in   = (first_x > lim) ? AW'(LEAVES) : AW'(first_x);
  assign hi_in   = (end_x > lim) ? AW'(LEAVES) : AW'(end_x);

  assign pos      = sel ? LOG'(hi - AW'(1)) : lo[LOG-1:0];
  assign leaf_pos = {1'b1, pos};
  assign push_i   = leaf_pos >> s;

  assign s_tready = (state == ST_IDLE);

  // Memories: one write and one registered read each per cycle.
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_wa] <= node_wd;
    end
    if (pend_we) begin
      pend_mem[pend_wa] <= pend_wd;
    end
    node_rd <= node_mem[node_ra];
    pend_rd <= pend_mem[pend_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory control.
  always_comb begin
    state_next = state;
    node_ra    = '0;
    pend_ra    = '0;
    node_we    = 1'b0;
    node_wa    = '0;
    node_wd    = '0;
    pend_we    = 1'b0;
    pend_wa    = '0;
    pend_wd    = '0;
    case (state)
      ST_CLEAR: begin
        node_we = 1'b1;
        node_wa = clr_cnt;
        pend_we = 1'b1;
        pend_wa = clr_cnt[LOG-1:0];
        if (clr_cnt == AW'(2*LEAVES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_tvalid) begin
          if (hi_in <= lo_in) begin
            state_next = s_tuser ? ST_OUT : ST_IDLE;
          end else begin
            state_next = ST_PUSH_RD;
          end
        end
      end
      ST_PUSH_RD: begin
        pend_ra    = push_i[LOG-1:0];
        state_next = ST_PUSH_CHK;
      end
      ST_PUSH_CHK: begin
        state_next = (pend_rd == '0) ? ST_PUSH_NEXT : ST_GIVE_RD;
      end
      ST_PUSH_C1: begin
        state_next = ST_GIVE_RD;
      end
      ST_PUSH_CLR: begin
        pend_we    = 1'b1;
        pend_wa    = pi[LOG-1:0];
        state_next = ST_PUSH_NEXT;
      end
      ST_PUSH_NEXT: begin
        if (s == SW'(1)) begin
          state_next = sel ? ST_SCAN : ST_PUSH_RD;
        end else begin
          state_next = ST_PUSH_RD;
        end
      end
      ST_GIVE_RD: begin
        node_ra    = gaddr;
        pend_ra    = gaddr[LOG-1:0];
        state_next = ST_GIVE_WR;
      end
      ST_GIVE_WR: begin
        node_we    = 1'b1;
        node_wa    = gaddr;
        node_wd    = node_rd + (gamt << gshift);
        pend_we    = (gaddr < AW'(LEAVES));
        pend_wa    = gaddr[LOG-1:0];
        pend_wd    = pend_rd + gamt;
        state_next = gret;
      end
      ST_SCAN: begin
        if (l >= r) begin
          state_next = (act == 1'(ACTION_ADD)) ? ST_REB_A : ST_OUT;
        end else if (l[0]) begin
          node_ra    = l[AW-1:0];
          state_next = (act == 1'(ACTION_ADD)) ? ST_GIVE_RD : ST_QACC;
        end else begin
          state_next = ST_SCAN_R;
        end
      end
      ST_SCAN_R: begin
        if (r[0]) begin
          node_ra    = AW'(r - (AW+1)'(1));
          state_next = (act == 1'(ACTION_ADD)) ? ST_GIVE_RD : ST_QACC;
        end else begin
          state_next = ST_SCAN_SH;
        end
      end
      ST_SCAN_SH: begin
        state_next = ST_SCAN;
      end
      ST_QACC: begin
        state_next = gret;
      end
      ST_REB_A: begin
        if (p == '0) begin
          state_next = sel ? ST_IDLE : ST_REB_A;
        end else begin
          node_ra    = AW'({p, 1'b0});
          pend_ra    = p[LOG-1:0];
          state_next = ST_REB_B;
        end
      end
      ST_REB_B: begin
        node_ra    = AW'({p, 1'b1});
        state_next = ST_REB_W;
      end
      ST_REB_W: begin
        node_we    = 1'b1;
        node_wa    = p;
        node_wd    = a_sum + node_rd + (pd << k);
        state_next = ST_REB_A;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath registers, stepped by the sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // The output state reloads the result register itself, so the plain
      // drain only applies elsewhere.
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
        end
        ST_IDLE: begin
          act <= s_tuser;
          amt <= s_tdata[84:21];
          lo  <= lo_in;
          hi  <= hi_in;
          sel <= 1'b0;
          s   <= SW'(LOG);
          acc <= '0;
          l   <= {1'b0, lo_in} + (AW+1)'(LEAVES);
          r   <= {1'b0, hi_in} + (AW+1)'(LEAVES);
          lvl <= '0;
        end
        ST_PUSH_RD: begin
          pi <= push_i;
        end
        ST_PUSH_CHK: begin
          pd     <= pend_rd;
          gamt   <= pend_rd;
          gshift <= s - SW'(1);
          gaddr  <= AW'({pi, 1'b0});
          gret   <= ST_PUSH_C1;
        end
        ST_PUSH_C1: begin
          gaddr <= AW'({pi, 1'b1});
          gret  <= ST_PUSH_CLR;
        end
        ST_PUSH_NEXT: begin
          if (s == SW'(1)) begin
            sel <= ~sel;
            s   <= SW'(LOG);
          end else begin
            s <= s - SW'(1);
          end
        end
        ST_SCAN: begin
          if (l >= r) begin
            sel <= 1'b0;
            p   <= AW'({1'b1, lo[LOG-1:0]} >> 1);
            k   <= SW'(1);
          end else if (l[0]) begin
            gaddr  <= l[AW-1:0];
            gshift <= lvl;
            gamt   <= amt;
            gret   <= ST_SCAN_R;
            l      <= l + (AW+1)'(1);
          end
        end
        ST_SCAN_R: begin
          if (r[0]) begin
            gaddr  <= AW'(r - (AW+1)'(1));
            gshift <= lvl;
            gamt   <= amt;
            gret   <= ST_SCAN_SH;
            r      <= r - (AW+1)'(1);
          end
        end
        ST_SCAN_SH: begin
          l   <= l >> 1;
          r   <= r >> 1;
          lvl <= lvl + SW'(1);
        end
        ST_QACC: begin
          acc <= acc + node_rd;
        end
        ST_REB_A: begin
          if (p == '0) begin
            sel <= 1'b1;
            p   <= AW'({1'b1, LOG'(hi - AW'(1))} >> 1);
            k   <= SW'(1);
          end
        end
        ST_REB_B: begin
          a_sum <= node_rd;
          pd    <= pend_rd;
        end
        ST_REB_W: begin
          p <= p >> 1;
          k <= k + SW'(1);
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= acc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // A result only appears from the output hand-off state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_OUT)
    else $error("result raised outside the output state");

  // No transaction is taken while the memories are being swept.
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> clr_cnt == AW'(2*LEAVES - 1) || clr_cnt == '0)
    else $error("input ready before the clearing sweep finished");

  // The range walk never climbs past the root.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> lvl <= SW'(LOG + 1))
    else $error("range walk level out of bounds");

  // Rebuild only writes internal nodes.
  assert property (@(posedge clk) disable iff (rst)
    state == ST_REB_W |-> p < AW'(LEAVES) && p != '0)
    else $error("rebuild addressed a non-internal node");

endmodule
